// ----- sv/pgmh_pkg.sv -----
// Shared types and constants of the polar grid max-height binner.
// Holds opcodes, result codes, register indexes and the arctangent table.
// No dependencies.
package pgmh_pkg;

  localparam int CORDIC_STEPS = 24;
  localparam int ANG_W        = 32;
  localparam int RANGE_W      = 23;
  localparam int RCOUNT_W     = 5;

  localparam logic [1:0] OP_CLEAR = 2'd0;
  localparam logic [1:0] OP_ADD   = 2'd1;
  localparam logic [1:0] OP_READ  = 2'd2;

  localparam logic [2:0] ST_CLEARED  = 3'd0;
  localparam logic [2:0] ST_BINNED   = 3'd1;
  localparam logic [2:0] ST_DROPPED  = 3'd2;
  localparam logic [2:0] ST_READ     = 3'd3;
  localparam logic [2:0] ST_BAD_READ = 3'd4;

  localparam logic REG_RING_COUNT = 1'b0;
  localparam logic REG_RANGE      = 1'b1;

  localparam logic [ANG_W-1:0] ATAN_TURNS [CORDIC_STEPS] = '{
    32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
    32'd21354465, 32'd10679838, 32'd5340245, 32'd2670163, 32'd1335087,
    32'd667544, 32'd333772, 32'd166886, 32'd83443, 32'd41722, 32'd20861,
    32'd10430, 32'd5215, 32'd2608, 32'd1304, 32'd652, 32'd326, 32'd163, 32'd81
  };

  typedef struct packed {
    logic done;
    logic drop;
  } ring_stat_t;

endpackage

// ----- sv/pgmh_ring.sv -----
// Radial unit: range check and ring search by stepped squared compares.
// Depends on pgmh_pkg.
module pgmh_ring #(
  parameter int MAX_RINGS  = 20,
  parameter int COORD_BITS = 24,
  localparam int RB  = (MAX_RINGS > 1) ? $clog2(MAX_RINGS) : 1,
  localparam int RB1 = $clog2(MAX_RINGS + 1)
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  logic [COORD_BITS-1:0]     ax,
  input  logic [COORD_BITS-1:0]     ay,
  input  logic [pgmh_pkg::RANGE_W-1:0] range_mm,
  input  logic [RB1-1:0]            rings,
  output pgmh_pkg::ring_stat_t      stat,
  output logic [RB-1:0]             ring
);
  import pgmh_pkg::*;

  localparam int CW   = COORD_BITS;
  localparam int R2W  = 2 * CW;
  localparam int LIMW = 2 * RANGE_W;
  localparam int RRW  = 2 * RB1 + LIMW;
  localparam int KRW  = RB + RANGE_W;
  localparam int KSQW = 2 * KRW;
  localparam int C1W  = (R2W > LIMW) ? R2W : LIMW;
  localparam int C2W  = (RRW > KSQW) ? RRW : KSQW;

  typedef enum logic [2:0] {R_IDLE, R_SQ, R_CHK, R_RR, R_KSQ, R_KCMP} rstate_t;

  rstate_t           state_r;
  logic [CW-1:0]     ax_r, ay_r;
  logic [R2W-1:0]    sqx_r, sqy_r;
  logic [LIMW-1:0]   lim2_r, r2_r;
  logic [2*RB1-1:0]  rsq_r;
  logic [RRW-1:0]    rr_r;
  logic [KRW-1:0]    kr_r;
  logic [KSQW-1:0]   ksq_r;
  logic [RB-1:0]     k_r;
  logic              done_r, drop_r;
  logic [R2W-1:0]    r2_sum;

  assign r2_sum = sqx_r + sqy_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= R_IDLE;
      done_r  <= 1'b0;
      drop_r  <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        ax_r    <= ax;
        ay_r    <= ay;
        state_r <= R_SQ;
      end else begin
        unique case (state_r)
          R_IDLE: begin
          end
          R_SQ: begin
            sqx_r   <= R2W'(ax_r) * R2W'(ax_r);
            sqy_r   <= R2W'(ay_r) * R2W'(ay_r);
            lim2_r  <= LIMW'(range_mm) * LIMW'(range_mm);
            rsq_r   <= (2*RB1)'(rings) * (2*RB1)'(rings);
            kr_r    <= KRW'(rings - RB1'(1)) * KRW'(range_mm);
            k_r     <= RB'(rings - RB1'(1));
            state_r <= R_CHK;
          end
          R_CHK: begin
            if (C1W'(r2_sum) >= C1W'(lim2_r)) begin
              done_r  <= 1'b1;
              drop_r  <= 1'b1;
              state_r <= R_IDLE;
            end else begin
              r2_r    <= LIMW'(r2_sum);
              state_r <= R_RR;
            end
          end
          R_RR: begin
            rr_r    <= RRW'(rsq_r) * RRW'(r2_r);
            state_r <= R_KSQ;
          end
          R_KSQ: begin
            ksq_r   <= KSQW'(kr_r) * KSQW'(kr_r);
            state_r <= R_KCMP;
          end
          R_KCMP: begin
            if (k_r != '0 && C2W'(ksq_r) > C2W'(rr_r)) begin
              k_r     <= k_r - RB'(1);
              kr_r    <= kr_r - KRW'(range_mm);
              state_r <= R_KSQ;
            end else begin
              done_r  <= 1'b1;
              drop_r  <= 1'b0;
              state_r <= R_IDLE;
            end
          end
          default: state_r <= R_IDLE;
        endcase
      end
    end
  end

  assign stat.done = done_r;
  assign stat.drop = drop_r;
  assign ring      = k_r;

endmodule

// ----- sv/pgmh_azimuth.sv -----
// Azimuth unit: CORDIC vectoring, one rotation a cycle, then sector scaling.
// Depends on pgmh_pkg.
module pgmh_azimuth #(
  parameter int SECTORS    = 60,
  parameter int COORD_BITS = 24,
  localparam int SB = (SECTORS > 1) ? $clog2(SECTORS) : 1
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic signed [COORD_BITS-1:0] x,
  input  logic signed [COORD_BITS-1:0] y,
  output logic                         done,
  output logic [SB-1:0]                sector
);
  import pgmh_pkg::*;

  localparam int W   = COORD_BITS + 34;
  localparam int PW  = ANG_W + $clog2(SECTORS + 1);
  localparam int IW  = $clog2(CORDIC_STEPS);
  localparam logic [ANG_W-1:0] HALF = {1'b1, {(ANG_W-1){1'b0}}};

  typedef enum logic [1:0] {A_IDLE, A_ITER, A_FIX, A_MUL} astate_t;

  astate_t            state_r;
  logic signed [W-1:0] cx_r, cy_r, xe, ye, dx, dy;
  logic [ANG_W-1:0]   ang_r;
  logic [IW-1:0]      i_r;
  logic               ypos_r, yneg_r, xnn_r;
  logic [PW-1:0]      prod_r;
  logic [PW-ANG_W-1:0] sect;
  logic               done_r;
  logic [SB-1:0]      sector_r;

  assign xe   = W'(x);
  assign ye   = W'(y);
  assign dx   = cy_r >>> i_r;
  assign dy   = cx_r >>> i_r;
  assign sect = prod_r[PW-1:ANG_W];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= A_IDLE;
      done_r  <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        cx_r    <= (x < 0) ? ((-xe) <<< 32) : (xe <<< 32);
        cy_r    <= (x < 0) ? ((-ye) <<< 32) : (ye <<< 32);
        ang_r   <= (x < 0) ? HALF : '0;
        ypos_r  <= (y > 0);
        yneg_r  <= (y < 0);
        xnn_r   <= (x >= 0);
        i_r     <= '0;
        state_r <= A_ITER;
      end else begin
        unique case (state_r)
          A_IDLE: begin
          end
          A_ITER: begin
            if (cy_r > 0) begin
              cx_r  <= cx_r + dx;
              cy_r  <= cy_r - dy;
              ang_r <= ang_r + ATAN_TURNS[i_r];
            end else if (cy_r < 0) begin
              cx_r  <= cx_r - dx;
              cy_r  <= cy_r + dy;
              ang_r <= ang_r - ATAN_TURNS[i_r];
            end
            if (i_r == IW'(CORDIC_STEPS - 1)) begin
              state_r <= A_FIX;
            end else begin
              i_r <= i_r + IW'(1);
            end
          end
          A_FIX: begin
            if (ypos_r && ang_r > HALF) begin
              ang_r <= xnn_r ? '0 : (HALF - ANG_W'(1));
            end else if (yneg_r && ang_r <= HALF) begin
              ang_r <= xnn_r ? '1 : (HALF + ANG_W'(1));
            end
            state_r <= A_MUL;
          end
          A_MUL: begin
            prod_r  <= PW'(ang_r) * PW'(SECTORS);
            state_r <= A_IDLE;
            done_r  <= 1'b1;
          end
          default: state_r <= A_IDLE;
        endcase
      end
    end
  end

  always_comb begin
    if (int'(sect) >= SECTORS) begin
      sector_r = SB'(SECTORS - 1);
    end else begin
      sector_r = SB'(sect);
    end
  end

  assign done   = done_r;
  assign sector = sector_r;

endmodule

// ----- sv/polar_grid_max_height_binner_unit.sv -----
// Top level of the polar grid max-height binner: grid memory, sequencer, registers.
// Depends on pgmh_pkg, pgmh_ring and pgmh_azimuth.
//
//  channel  | handshake            | payload
//  ---------+----------------------+---------------------------------------------
//  input    | start / busy         | in_opcode, in_point_x/y/z, in_ring/sector_select
//  result   | out_strobe           | out_status, out_ring/sector_index, out_cell_*
//  config   | psel/penable/pwrite  | paddr, pwdata, prdata, pready
//
// Add: waits for both the 24-step CORDIC and the ring search, then reads and writes the cell;
// a dropped point skips the grid access.
// Read: goes through the registered memory port. Invalid ops answer without a memory access.
// Clear: sweeps all MAX_RINGS*SECTORS entries, one grid entry a cycle.
// After reset the same sweep runs with busy high.
// One beat per item; the result beat cannot be stalled.
module polar_grid_max_height_binner_unit #(
  parameter int MAX_RINGS  = 20,
  parameter int SECTORS    = 60,
  parameter int COORD_BITS = 24
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         in_opcode,
  input  logic signed [23:0] in_point_x,
  input  logic signed [23:0] in_point_y,
  input  logic signed [23:0] in_point_z,
  input  logic [4:0]         in_ring_select,
  input  logic [5:0]         in_sector_select,
  output logic               out_strobe,
  output logic [2:0]         out_status,
  output logic [4:0]         out_ring_index,
  output logic [5:0]         out_sector_index,
  output logic signed [23:0] out_cell_height,
  output logic               out_cell_occupied,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);
  import pgmh_pkg::*;

  localparam int CW    = COORD_BITS;
  localparam int CELLS = MAX_RINGS * SECTORS;
  localparam int AW    = (CELLS > 1) ? $clog2(CELLS) : 1;
  localparam int RB    = (MAX_RINGS > 1) ? $clog2(MAX_RINGS) : 1;
  localparam int RB1   = $clog2(MAX_RINGS + 1);
  localparam int SB    = (SECTORS > 1) ? $clog2(SECTORS) : 1;

  typedef enum logic [2:0] {
    T_CLEAR, T_IDLE, T_ADD_WAIT, T_ADD_RD, T_ADD_WB, T_RD_RD, T_RD_OUT, T_EMIT
  } tstate_t;

  tstate_t              state_r;
  logic [RCOUNT_W-1:0]  ring_count_r;
  logic [RANGE_W-1:0]   range_r;
  logic [RB1-1:0]       rings_use;
  logic                 accept, cfg_wr;

  logic signed [CW-1:0] xc, yc, zc, z_r;
  logic [CW-1:0]        axc, ayc;
  logic                 clr_op_r;
  logic [AW-1:0]        clr_addr_r, cell_r, waddr;
  logic                 rdone_r, adone_r, drop_r;
  logic [RB-1:0]        ring_r;
  logic [SB-1:0]        sect_r;
  logic [4:0]           psel_ring_r;
  logic [5:0]           psel_sect_r;
  logic [2:0]           pend_status_r;

  ring_stat_t           rstat;
  logic [RB-1:0]        ring_w;
  logic                 az_done;
  logic [SB-1:0]        sect_w;

  logic [CW:0]          grid_mem [CELLS];
  logic [CW:0]          rdata_r, wdata;
  logic                 mem_we;
  logic signed [CW-1:0] old_h, new_h;
  logic                 upd;

  logic                 out_strobe_r, out_occ_r;
  logic [2:0]           out_status_r;
  logic [4:0]           out_ring_r;
  logic [5:0]           out_sect_r;
  logic signed [23:0]   out_h_r;

  assign accept = start && !busy;
  assign cfg_wr = psel && penable && pwrite && pready;
  assign busy   = (state_r != T_IDLE);
  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_RANGE) ? 32'(range_r) : 32'(ring_count_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ring_count_r <= 5'd20;
      range_r      <= 23'd80000;
    end else if (cfg_wr) begin
      if (paddr[2] == REG_RING_COUNT) begin
        ring_count_r <= pwdata[RCOUNT_W-1:0];
      end else begin
        range_r <= pwdata[RANGE_W-1:0];
      end
    end
  end

  always_comb begin
    if (ring_count_r == '0) begin
      rings_use = RB1'(1);
    end else if (int'(ring_count_r) > MAX_RINGS) begin
      rings_use = RB1'(MAX_RINGS);
    end else begin
      rings_use = RB1'(ring_count_r);
    end
  end

  assign xc  = CW'($unsigned(in_point_x));
  assign yc  = CW'($unsigned(in_point_y));
  assign zc  = CW'($unsigned(in_point_z));
  assign axc = (xc < 0) ? CW'(-xc) : CW'(xc);
  assign ayc = (yc < 0) ? CW'(-yc) : CW'(yc);

  pgmh_ring #(.MAX_RINGS(MAX_RINGS), .COORD_BITS(COORD_BITS)) u_ring (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (accept && in_opcode == OP_ADD),
    .ax       (axc),
    .ay       (ayc),
    .range_mm (range_r),
    .rings    (rings_use),
    .stat     (rstat),
    .ring     (ring_w)
  );

  pgmh_azimuth #(.SECTORS(SECTORS), .COORD_BITS(COORD_BITS)) u_azimuth (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (accept && in_opcode == OP_ADD),
    .x      (xc),
    .y      (yc),
    .done   (az_done),
    .sector (sect_w)
  );

  assign old_h  = rdata_r[CW-1:0];
  assign upd    = !rdata_r[CW] || (z_r > old_h);
  assign new_h  = upd ? z_r : old_h;
  assign mem_we = (state_r == T_CLEAR) || (state_r == T_ADD_WB);
  assign waddr  = (state_r == T_CLEAR) ? clr_addr_r : cell_r;
  assign wdata  = (state_r == T_CLEAR) ? {1'b0, {CW{1'b0}}} : {1'b1, new_h};

  always_ff @(posedge clk) begin
    if (mem_we) begin
      grid_mem[waddr] <= wdata;
    end
    rdata_r <= grid_mem[cell_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= T_CLEAR;
      clr_addr_r   <= '0;
      clr_op_r     <= 1'b0;
      rdone_r      <= 1'b0;
      adone_r      <= 1'b0;
      out_strobe_r <= 1'b0;
    end else begin
      out_strobe_r <= 1'b0;
      if (rstat.done) begin
        rdone_r <= 1'b1;
        drop_r  <= rstat.drop;
        ring_r  <= ring_w;
      end
      if (az_done) begin
        adone_r <= 1'b1;
        sect_r  <= sect_w;
      end
      unique case (state_r)
        T_CLEAR: begin
          clr_addr_r <= clr_addr_r + AW'(1);
          if (clr_addr_r == AW'(CELLS - 1)) begin
            clr_addr_r <= '0;
            state_r    <= T_IDLE;
            if (clr_op_r) begin
              out_strobe_r <= 1'b1;
              out_status_r <= ST_CLEARED;
              out_ring_r   <= '0;
              out_sect_r   <= '0;
              out_h_r      <= '0;
              out_occ_r    <= 1'b0;
            end
          end
        end
        T_IDLE: begin
          if (accept) begin
            psel_ring_r <= in_ring_select;
            psel_sect_r <= in_sector_select;
            z_r         <= zc;
            unique case (in_opcode)
              OP_CLEAR: begin
                clr_op_r <= 1'b1;
                state_r  <= T_CLEAR;
              end
              OP_ADD: begin
                rdone_r <= 1'b0;
                adone_r <= 1'b0;
                state_r <= T_ADD_WAIT;
              end
              OP_READ: begin
                if (int'(in_ring_select) < int'(rings_use) &&
                    int'(in_sector_select) < SECTORS) begin
                  cell_r  <= AW'(int'(in_ring_select) * SECTORS + int'(in_sector_select));
                  state_r <= T_RD_RD;
                end else begin
                  pend_status_r <= ST_BAD_READ;
                  state_r       <= T_EMIT;
                end
              end
              default: begin
                pend_status_r <= ST_BAD_READ;
                psel_ring_r   <= '0;
                psel_sect_r   <= '0;
                state_r       <= T_EMIT;
              end
            endcase
          end
        end
        T_ADD_WAIT: begin
          if (rdone_r && adone_r) begin
            if (drop_r) begin
              pend_status_r <= ST_DROPPED;
              psel_ring_r   <= '0;
              psel_sect_r   <= '0;
              state_r       <= T_EMIT;
            end else begin
              cell_r  <= AW'(int'(ring_r) * SECTORS + int'(sect_r));
              state_r <= T_ADD_RD;
            end
          end
        end
        T_ADD_RD: begin
          state_r <= T_ADD_WB;
        end
        T_ADD_WB: begin
          out_strobe_r <= 1'b1;
          out_status_r <= ST_BINNED;
          out_ring_r   <= 5'(ring_r);
          out_sect_r   <= 6'(sect_r);
          out_h_r      <= 24'(new_h);
          out_occ_r    <= 1'b1;
          state_r      <= T_IDLE;
        end
        T_RD_RD: begin
          state_r <= T_RD_OUT;
        end
        T_RD_OUT: begin
          out_strobe_r <= 1'b1;
          out_status_r <= ST_READ;
          out_ring_r   <= psel_ring_r;
          out_sect_r   <= psel_sect_r;
          out_h_r      <= rdata_r[CW] ? 24'(old_h) : '0;
          out_occ_r    <= rdata_r[CW];
          state_r      <= T_IDLE;
        end
        T_EMIT: begin
          out_strobe_r <= 1'b1;
          out_status_r <= pend_status_r;
          out_ring_r   <= psel_ring_r;
          out_sect_r   <= psel_sect_r;
          out_h_r      <= '0;
          out_occ_r    <= 1'b0;
          state_r      <= T_IDLE;
        end
        default: state_r <= T_IDLE;
      endcase
    end
  end

  assign out_strobe        = out_strobe_r;
  assign out_status        = out_status_r;
  assign out_ring_index    = out_ring_r;
  assign out_sector_index  = out_sect_r;
  assign out_cell_height   = out_h_r;
  assign out_cell_occupied = out_occ_r;

`ifndef SYNTH
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> busy) else $error("accepted beat did not raise busy");
  a_strobe_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> !busy) else $error("result beat while busy");
  a_binned_occ: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_status == ST_BINNED) |-> out_cell_occupied)
    else $error("binned point left cell empty");
  a_clear_wr: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == T_CLEAR) |-> (mem_we && !wdata[CW]))
    else $error("clear sweep wrote an occupied entry");
`endif

endmodule

// ----- sim/pgmh_scoreboard.sv -----
// Watches the item, result and register channels of the polar grid binner,
// predicts each result from its own copy of the grid and registers, and counts mismatches.
// Depends on pgmh_pkg.
module pgmh_scoreboard (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic               busy,
  input  logic [1:0]         in_opcode,
  input  logic signed [23:0] in_point_x,
  input  logic signed [23:0] in_point_y,
  input  logic signed [23:0] in_point_z,
  input  logic [4:0]         in_ring_select,
  input  logic [5:0]         in_sector_select,
  input  logic               out_strobe,
  input  logic [2:0]         out_status,
  input  logic [4:0]         out_ring_index,
  input  logic [5:0]         out_sector_index,
  input  logic signed [23:0] out_cell_height,
  input  logic               out_cell_occupied,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic               pready,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output int                 fail_count,
  output int                 pending
);
  timeunit 1ns;
  timeprecision 1ps;
  import pgmh_pkg::*;

  localparam int GRID_RINGS   = 20;
  localparam int GRID_SECTORS = 60;
  localparam int GRID_CELLS   = GRID_RINGS * GRID_SECTORS;

  typedef struct packed {
    logic [2:0]         status;
    logic [4:0]         ring;
    logic [5:0]         sector;
    logic signed [23:0] height;
    logic               occupied;
  } cell_result_t;

  logic [4:0]         ring_count_reg;
  logic [22:0]        range_mm_reg;
  logic signed [23:0] cell_height_q [GRID_CELLS];
  logic               cell_occ_q [GRID_CELLS];
  cell_result_t       expected_cells [$];

  function automatic logic [31:0] azimuth_turns(longint x, longint y);
    logic [31:0] a;
    longint cx, cy, dx, dy;
    a = '0;
    cx = x;
    cy = y;
    if (cx < 0) begin
      cx = -cx;
      cy = -cy;
      a = 32'h8000_0000;
    end
    cx = cx * 64'sh1_0000_0000;
    cy = cy * 64'sh1_0000_0000;
    for (int i = 0; i < CORDIC_STEPS; i++) begin
      if (cy == 0) break;
      dx = cy >>> i;
      dy = cx >>> i;
      if (cy > 0) begin
        cx += dx; cy -= dy; a += ATAN_TURNS[i];
      end else begin
        cx -= dx; cy += dy; a -= ATAN_TURNS[i];
      end
    end
    if (y > 0 && a > 32'h8000_0000) a = (x >= 0) ? 32'h0 : 32'h7FFF_FFFF;
    if (y < 0 && a <= 32'h8000_0000) a = (x >= 0) ? 32'hFFFF_FFFF : 32'h8000_0001;
    return a;
  endfunction

  function cell_result_t bin_or_read(logic [1:0] op, logic signed [23:0] px,
                                     logic signed [23:0] py, logic signed [23:0] pz,
                                     logic [4:0] rsel, logic [5:0] ssel);
    cell_result_t r;
    longint unsigned rings, r2, lim2, rr, ring, sector, ax, ay;
    int cell_idx;
    r = '{default: '0};
    rings = (ring_count_reg == 0) ? 1 :
            (ring_count_reg > GRID_RINGS) ? GRID_RINGS : ring_count_reg;
    case (op)
      OP_CLEAR: begin
        foreach (cell_occ_q[i]) cell_occ_q[i] = 1'b0;
        r.status = ST_CLEARED;
      end
      OP_ADD: begin
        ax = (px < 0) ? -longint'(px) : longint'(px);
        ay = (py < 0) ? -longint'(py) : longint'(py);
        r2 = ax * ax + ay * ay;
        lim2 = longint'(range_mm_reg) * longint'(range_mm_reg);
        if (r2 >= lim2) begin
          r.status = ST_DROPPED;
        end else begin
          rr = rings * rings * r2;
          ring = rings - 1;
          while (ring > 0 && (ring * range_mm_reg) * (ring * range_mm_reg) > rr) ring--;
          sector = (longint'(azimuth_turns(px, py)) * GRID_SECTORS) >> 32;
          if (sector >= GRID_SECTORS) sector = GRID_SECTORS - 1;
          cell_idx = int'(ring * GRID_SECTORS + sector);
          if (!cell_occ_q[cell_idx] || pz > cell_height_q[cell_idx]) begin
            cell_height_q[cell_idx] = pz;
            cell_occ_q[cell_idx] = 1'b1;
          end
          r.status = ST_BINNED;
          r.ring = ring[4:0];
          r.sector = sector[5:0];
          r.height = cell_height_q[cell_idx];
          r.occupied = 1'b1;
        end
      end
      OP_READ: begin
        r.ring = rsel;
        r.sector = ssel;
        if (rsel < rings && ssel < GRID_SECTORS) begin
          cell_idx = rsel * GRID_SECTORS + ssel;
          r.status = ST_READ;
          if (cell_occ_q[cell_idx]) begin
            r.height = cell_height_q[cell_idx];
            r.occupied = 1'b1;
          end
        end else begin
          r.status = ST_BAD_READ;
        end
      end
      default: r.status = ST_BAD_READ;
    endcase
    return r;
  endfunction

  always @(posedge clk) begin
    cell_result_t got, want;
    if (!rst_n) begin
      ring_count_reg <= 5'd20;
      range_mm_reg <= 23'd80000;
      foreach (cell_occ_q[i]) cell_occ_q[i] = 1'b0;
      expected_cells.delete();
      fail_count <= 0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        if (paddr[2] == REG_RING_COUNT) ring_count_reg <= pwdata[4:0];
        else range_mm_reg <= pwdata[22:0];
      end
      if (out_strobe) begin
        got = '{out_status, out_ring_index, out_sector_index, out_cell_height,
                out_cell_occupied};
        if (expected_cells.size() == 0) begin
          $error("result beat with nothing expected: status %0d", out_status);
          fail_count <= fail_count + 1;
        end else begin
          want = expected_cells.pop_front();
          if (got != want) begin
            if (got.status != want.status)
              $error("status: expected %0d, got %0d", want.status, got.status);
            if (got.ring != want.ring)
              $error("ring_index: expected %0d, got %0d", want.ring, got.ring);
            if (got.sector != want.sector)
              $error("sector_index: expected %0d, got %0d", want.sector, got.sector);
            if (got.height != want.height)
              $error("cell_height: expected %0d, got %0d", want.height, got.height);
            if (got.occupied != want.occupied)
              $error("cell_occupied: expected %0d, got %0d", want.occupied, got.occupied);
            fail_count <= fail_count + 1;
          end
        end
      end
      if (start && !busy)
        expected_cells.push_back(bin_or_read(in_opcode, in_point_x, in_point_y, in_point_z,
                                             in_ring_select, in_sector_select));
    end
    pending <= expected_cells.size();
  end

endmodule

// ----- sim/polar_grid_max_height_binner_unit_tb.sv -----
// Testbench top of the polar grid max-height binner: clock, reset, register
// writes and item stimulus across several settings.
// Depends on pgmh_pkg, the block and pgmh_scoreboard.
module polar_grid_max_height_binner_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import pgmh_pkg::*;

  localparam logic [1:0] OP_UNUSED = 2'd3;

  logic clk = 1'b0, rst_n = 1'b0, start = 1'b0, busy;
  logic [1:0] in_opcode = '0;
  logic signed [23:0] in_point_x = '0, in_point_y = '0, in_point_z = '0;
  logic [4:0] in_ring_select = '0;
  logic [5:0] in_sector_select = '0;
  logic out_strobe, out_cell_occupied;
  logic [2:0] out_status;
  logic [4:0] out_ring_index;
  logic [5:0] out_sector_index;
  logic signed [23:0] out_cell_height;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0, pready;
  logic [2:0] paddr = '0;
  logic [31:0] pwdata = '0, prdata;
  int fail_count, pending, items, phases;
  int unsigned cur_rings, cur_range;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  polar_grid_max_height_binner_unit dut (.*);

  pgmh_scoreboard u_scoreboard (.*);

  task automatic drive_item(logic [1:0] op, int x, int y, int z, int rs, int ss);
    start <= 1'b1;
    in_opcode <= op;
    in_point_x <= x[23:0];
    in_point_y <= y[23:0];
    in_point_z <= z[23:0];
    in_ring_select <= rs[4:0];
    in_sector_select <= ss[5:0];
    do @(negedge clk); while (busy);
    @(posedge clk);
    items++;
    if ($urandom_range(0, 3) != 0) begin
      start <= 1'b0;
      if ($urandom_range(0, 9) == 0) repeat ($urandom_range(20, 150)) @(posedge clk);
      else repeat ($urandom_range(1, 4)) @(posedge clk);
    end
  endtask

  task automatic drain();
    start <= 1'b0;
    do @(negedge clk); while (busy || pending != 0);
    @(posedge clk);
  endtask

  task automatic write_reg(logic idx, int unsigned value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_config(int unsigned rings, int unsigned range_mm);
    drain();
    write_reg(REG_RING_COUNT, rings);
    write_reg(REG_RANGE, range_mm);
    cur_rings = rings;
    cur_range = range_mm;
    phases++;
  endtask

  function automatic int near_coord();
    int r;
    r = (cur_range > 6990000) ? 8388607 : int'(cur_range + cur_range / 5 + 1);
    if (r > 8388607) r = 8388607;
    return int'($urandom_range(0, 2 * r)) - r;
  endfunction

  task automatic random_item();
    int pick, x, y, rs, ss, used;
    pick = $urandom_range(0, 99);
    used = (cur_rings == 0) ? 1 : (cur_rings > 20) ? 20 : int'(cur_rings);
    if (pick < 2) begin
      drive_item(OP_CLEAR, $urandom, $urandom, $urandom, $urandom, $urandom);
    end else if (pick < 5) begin
      drive_item(OP_UNUSED, $urandom, $urandom, $urandom, $urandom, $urandom);
    end else if (pick < 65) begin
      if ($urandom_range(0, 4) == 0) begin
        x = $urandom;
        y = $urandom;
      end else begin
        x = near_coord();
        y = near_coord();
      end
      drive_item(OP_ADD, x, y, $urandom, $urandom, $urandom);
    end else begin
      if ($urandom_range(0, 5) == 0) begin
        rs = $urandom_range(0, 31);
        ss = $urandom_range(0, 63);
      end else begin
        rs = $urandom_range(0, used);
        ss = $urandom_range(0, 60);
      end
      drive_item(OP_READ, $urandom, $urandom, $urandom, rs, ss);
    end
  endtask

  initial begin
    items = 0;
    phases = 0;
    cur_rings = 20;
    cur_range = 80000;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    drain();

    drive_item(OP_READ, 0, 0, 0, 0, 0);
    drive_item(OP_ADD, 1000, 0, 5, 0, 0);
    drive_item(OP_ADD, 0, 1000, -8388608, 0, 0);
    drive_item(OP_ADD, -1000, 0, 8388607, 0, 0);
    drive_item(OP_ADD, 0, -1000, 0, 0, 0);
    drive_item(OP_ADD, 0, 0, 7, 0, 0);
    drive_item(OP_ADD, 0, 0, 3, 0, 0);
    drive_item(OP_ADD, 0, 0, 9, 0, 0);
    drive_item(OP_ADD, 79999, 0, 1, 0, 0);
    drive_item(OP_ADD, 80000, 0, 1, 0, 0);
    drive_item(OP_ADD, -8388608, -8388608, 1, 0, 0);
    drive_item(OP_ADD, 8388607, 8388607, 1, 0, 0);
    drive_item(OP_ADD, -30000, -1, 2, 0, 0);
    drive_item(OP_ADD, -30000, 1, 2, 0, 0);
    drive_item(OP_READ, 0, 0, 0, 0, 0);
    drive_item(OP_READ, 0, 0, 0, 19, 59);
    drive_item(OP_READ, 0, 0, 0, 20, 0);
    drive_item(OP_READ, 0, 0, 0, 0, 60);
    drive_item(OP_READ, 0, 0, 0, 31, 63);
    drive_item(OP_UNUSED, -1, -1, -1, 31, 63);
    drive_item(OP_CLEAR, 0, 0, 0, 0, 0);
    drive_item(OP_READ, 0, 0, 0, 0, 0);

    for (int p = 0; p < 10; p++) begin
      case (p)
        0: set_config(20, 80000);
        1: set_config(1, 1000);
        2: set_config(0, 5000);
        3: set_config(31, 8388607);
        4: set_config(7, 1);
        5: set_config(20, 0);
        6: set_config(3, 200);
        default: set_config($urandom_range(0, 31), $urandom_range(1, 8388607));
      endcase
      repeat (200) random_item();
    end
    set_config(5, 100000);
    drive_item(OP_READ, 0, 0, 0, 5, 0);
    drive_item(OP_READ, 0, 0, 0, 4, 59);

    start <= 1'b0;
    for (int w = 0; w < 20000 && pending != 0; w++) @(posedge clk);
    repeat (50) @(posedge clk);
    $display("Ran %0d items over %0d register settings,", items, phases);
    $display("including clears, drops, invalid reads and the unused opcode.");
    if (fail_count == 0 && pending == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("FAIL");
    $finish;
  end

endmodule
